FILE: rtl/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg: shared types and codes of the point-in-sector locator
// Operation codes, fixed field widths and the token that runs down the
// chain of sector cells.
// ----------------------------------------------------------------------------
package psl_pkg;

    localparam int OP_W          = 2;
    localparam int SLOT_W        = 8;
    localparam int SECTOR_W      = 6;
    localparam int COORD_FIELD_W = 16;

    localparam logic [OP_W-1:0] OP_WRITE_VERTEX = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND       = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR        = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY        = 2'd3;

    // Marker carried with each entry on its way through the crossing test.
    // scan flags the closing marker that follows the last entry of a query.
    typedef struct packed {
        logic vld;
        logic scan;
    } t_stage;

    // Token handed from cell to cell. For an entry: sec is the wall's sector,
    // hit that the wall is crossed. For the scan marker: sec is the highest
    // odd sector seen so far, hit that one was seen at all.
    typedef struct packed {
        logic                vld;
        logic                scan;
        logic [SECTOR_W-1:0] sec;
        logic                hit;
    } t_tok;

endpackage

FILE: rtl/point_in_sector_locator_unit.sv
// ----------------------------------------------------------------------------
// point_in_sector_locator_unit: point-in-sector locator
// Crossing-number test of a query point against a list of sector walls.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake               | Word
//  ---------+-----------+-------------------------+-----------------------------
//  in       | in        | i_in_valid / o_in_ready | op, slot, coords, wall entry
//  out      | out       | o_out_valid/ i_out_ready| sector, found, changed, full
//
//  Write vertex, append entry and clear entries are taken directly in IDLE.
//  A query reads its N entries one per cycle from the entry RAM; the scan
//  marker then passes the S sector cells (64 by default).
//  Reset clears entry count, current sector, overflow flag and all parities;
//  vertex and entry RAMs hold no reset value and need no clearing pass.
//  A query is taken only when the output register is free or being emptied.
// ----------------------------------------------------------------------------
module point_in_sector_locator_unit #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_ENTRIES  = 256,
    parameter int MAX_SECTORS  = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [psl_pkg::OP_W-1:0]                 i_op,
    input  logic [psl_pkg::SLOT_W-1:0]               i_vertex_slot,
    input  logic signed [psl_pkg::COORD_FIELD_W-1:0] i_coord_x,
    input  logic signed [psl_pkg::COORD_FIELD_W-1:0] i_coord_y,
    input  logic [psl_pkg::SLOT_W-1:0]               i_first_vertex,
    input  logic [psl_pkg::SLOT_W-1:0]               i_second_vertex,
    input  logic [psl_pkg::SECTOR_W-1:0]             i_sector_id,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [psl_pkg::SECTOR_W-1:0]             o_located_sector,
    output logic                                     o_inside_found,
    output logic                                     o_sector_changed,
    output logic                                     o_list_full
);
    import psl_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int VA    = $clog2(MAX_VERTICES);
    localparam int AW    = $clog2(MAX_ENTRIES);
    localparam int CNTW  = $clog2(MAX_ENTRIES + 1);
    localparam int EW    = SECTOR_W + 2 * SLOT_W;
    // sector ids are SECTOR_W bits wide, so no cell beyond that range
    localparam int NCELL = (MAX_SECTORS < (1 << SECTOR_W)) ? MAX_SECTORS : (1 << SECTOR_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [CNTW-1:0]      r_count, n_count;
    logic [CNTW-1:0]      r_idx, n_idx;
    logic                 r_ovf, n_ovf;
    logic [SECTOR_W-1:0]  r_cur, n_cur;
    t_stage               r_s1, n_s1;
    logic signed [CW-1:0] r_px, r_py;
    logic                 r_out_valid, n_out_valid;
    logic [SECTOR_W-1:0]  r_out_sector;
    logic                 r_out_found, r_out_changed, r_out_full;

    logic w_in_acc, w_slot_ok, w_full, w_more, w_vtx_we, w_ent_we, w_done;

    // ------------------------------------------------------------------
    // Input handshake: loads taken in IDLE, queries need a free output word
    // ------------------------------------------------------------------
    assign o_in_ready = (r_state == ST_IDLE) && ((i_op != OP_QUERY) || !r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_slot_ok  = int'(i_vertex_slot) < MAX_VERTICES;
    assign w_full     = r_count == CNTW'(MAX_ENTRIES);
    assign w_more     = r_idx < r_count;
    // drop writes to slots beyond the table
    assign w_vtx_we   = w_in_acc && (i_op == OP_WRITE_VERTEX) && w_slot_ok;
    // drop appends once the list is full
    assign w_ent_we   = w_in_acc && (i_op == OP_APPEND) && !w_full;

    // ------------------------------------------------------------------
    // Storage: two copies of the vertex table give two reads per cycle
    // ------------------------------------------------------------------
    logic [2*CW-1:0] w_vtx_wdata, w_vtx_a, w_vtx_b;
    logic [VA-1:0]   w_addr_a, w_addr_b;
    logic [EW-1:0]   w_ent_rdata;

    assign w_vtx_wdata = {CW'(i_coord_x), CW'(i_coord_y)};

    psl_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_vtx_a (
        .i_clk   (i_clk),
        .i_we    (w_vtx_we),
        .i_waddr (VA'(i_vertex_slot)),
        .i_wdata (w_vtx_wdata),
        .i_raddr (w_addr_a),
        .o_rdata (w_vtx_a)
    );

    psl_ram #(.WIDTH(2 * CW), .DEPTH(MAX_VERTICES)) u_vtx_b (
        .i_clk   (i_clk),
        .i_we    (w_vtx_we),
        .i_waddr (VA'(i_vertex_slot)),
        .i_wdata (w_vtx_wdata),
        .i_raddr (w_addr_b),
        .o_rdata (w_vtx_b)
    );

    psl_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata ({i_sector_id, i_first_vertex, i_second_vertex}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_ent_rdata)
    );

    // ------------------------------------------------------------------
    // Crossing test, then the chain of sector cells
    // ------------------------------------------------------------------
    t_tok w_chain [NCELL+1];
    t_tok w_tail;

    psl_cross #(.COORD_WIDTH(CW), .MAX_VERTICES(MAX_VERTICES)) u_cross (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_stage      (r_s1),
        .i_ent_sec    (w_ent_rdata[EW-1 -: SECTOR_W]),
        .i_ent_first  (w_ent_rdata[2*SLOT_W-1 -: SLOT_W]),
        .i_ent_second (w_ent_rdata[SLOT_W-1:0]),
        .i_px         (r_px),
        .i_py         (r_py),
        .o_addr_a     (w_addr_a),
        .o_addr_b     (w_addr_b),
        .i_vtx_a      (w_vtx_a),
        .i_vtx_b      (w_vtx_b),
        .o_tok        (w_chain[0])
    );

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        psl_cell #(.CELL_IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_chain[g]),
            .o_tok   (w_chain[g+1])
        );
    end

    assign w_tail = w_chain[NCELL];
    assign w_done = (r_state == ST_WAIT) && w_tail.vld && w_tail.scan;

    // ------------------------------------------------------------------
    // Control: loads in IDLE, walk the entries, wait for the scan marker
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_ovf       = r_ovf;
        n_cur       = r_cur;
        n_s1        = '{vld: 1'b0, scan: 1'b0};
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_op)
                        OP_WRITE_VERTEX: begin
                        end
                        OP_APPEND: begin
                            if (w_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        OP_QUERY: begin
                            n_idx   = '0;
                            n_state = ST_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WALK: begin
                if (w_more) begin
                    n_s1  = '{vld: 1'b1, scan: 1'b0};
                    n_idx = r_idx + 1'b1;
                end else begin
                    // close the query with the scan marker
                    n_s1    = '{vld: 1'b1, scan: 1'b1};
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                    if (w_tail.hit) begin
                        n_cur = w_tail.sec;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_ovf       <= 1'b0;
            r_cur       <= '0;
            r_s1        <= '{vld: 1'b0, scan: 1'b0};
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_ovf       <= n_ovf;
            r_cur       <= n_cur;
            r_s1        <= n_s1;
            r_out_valid <= n_out_valid;
        end
        if (w_in_acc && (i_op == OP_QUERY)) begin
            r_px <= CW'(i_coord_x);
            r_py <= CW'(i_coord_y);
        end
        if (w_done) begin
            r_out_sector  <= w_tail.hit ? w_tail.sec : r_cur;
            r_out_found   <= w_tail.hit;
            r_out_changed <= w_tail.hit && (w_tail.sec != r_cur);
            r_out_full    <= r_ovf;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_located_sector = r_out_sector;
    assign o_inside_found   = r_out_found;
    assign o_sector_changed = r_out_changed;
    assign o_list_full      = r_out_full;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_tail_scan_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tail.vld && w_tail.scan) |-> (r_state == ST_WAIT))
        else $error("scan marker left the chain outside a query");

    a_ovf_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> w_full)
        else $error("overflow flagged with room left in the list");

    a_changed_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sector_changed) |-> o_inside_found)
        else $error("sector changed without an odd sector");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_ENTRIES))
        else $error("entry count beyond list depth");

endmodule

FILE: rtl/psl_ram.sv
// ----------------------------------------------------------------------------
// psl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module psl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/psl_cross.sv
// ----------------------------------------------------------------------------
// psl_cross: wall crossing test
// Pipelined exact integer test of one wall entry per cycle against the
// query point; emits one token per entry plus the closing scan marker.
// ----------------------------------------------------------------------------
module psl_cross #(
    parameter int COORD_WIDTH  = 16,
    parameter int MAX_VERTICES = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psl_pkg::t_stage                     i_stage,
    input  logic [psl_pkg::SECTOR_W-1:0]        i_ent_sec,
    input  logic [psl_pkg::SLOT_W-1:0]          i_ent_first,
    input  logic [psl_pkg::SLOT_W-1:0]          i_ent_second,
    input  logic signed [COORD_WIDTH-1:0]       i_px,
    input  logic signed [COORD_WIDTH-1:0]       i_py,
    output logic [$clog2(MAX_VERTICES)-1:0]     o_addr_a,
    output logic [$clog2(MAX_VERTICES)-1:0]     o_addr_b,
    input  logic [2*COORD_WIDTH-1:0]            i_vtx_a,
    input  logic [2*COORD_WIDTH-1:0]            i_vtx_b,
    output psl_pkg::t_tok                       o_tok
);
    import psl_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int VA = $clog2(MAX_VERTICES);
    localparam int PW = 2 * CW + 2;

    // entry stage: index check and vertex read
    logic w_ok;

    assign w_ok     = (int'(i_ent_first) < MAX_VERTICES) && (int'(i_ent_second) < MAX_VERTICES);
    assign o_addr_a = VA'(i_ent_first);
    assign o_addr_b = VA'(i_ent_second);

    t_stage              r_s2;
    logic                r_s2_ok;
    logic [SECTOR_W-1:0] r_s2_sec;

    // vertex stage: coordinates relative to the point
    logic signed [CW-1:0] w_xa, w_ya, w_xb, w_yb;
    logic signed [CW:0]   w_x1, w_y1, w_x2, w_y2;

    assign w_xa = i_vtx_a[2*CW-1:CW];
    assign w_ya = i_vtx_a[CW-1:0];
    assign w_xb = i_vtx_b[2*CW-1:CW];
    assign w_yb = i_vtx_b[CW-1:0];
    assign w_x1 = (CW+1)'(w_xa) - (CW+1)'(i_px);
    assign w_y1 = (CW+1)'(w_ya) - (CW+1)'(i_py);
    assign w_x2 = (CW+1)'(w_xb) - (CW+1)'(i_px);
    assign w_y2 = (CW+1)'(w_yb) - (CW+1)'(i_py);

    t_stage              r_s3;
    logic                r_s3_ok;
    logic [SECTOR_W-1:0] r_s3_sec;
    logic signed [CW:0]  r_x1, r_y1, r_x2, r_y2;

    // product stage: straddle, slope direction and the two cross terms
    logic                w_straddle, w_cand, w_dxneg;
    logic signed [PW-1:0] w_p1, w_p2;

    assign w_straddle = ((r_x2 >= 0) && (r_x1 <= 0)) || ((r_x2 <= 0) && (r_x1 >= 0));
    assign w_cand     = r_s3_ok && w_straddle && (r_x1 != r_x2);
    assign w_dxneg    = r_x2 < r_x1;
    assign w_p1       = r_y1 * r_x2;
    assign w_p2       = r_y2 * r_x1;

    t_stage               r_s4;
    logic [SECTOR_W-1:0]  r_s4_sec;
    logic                 r_s4_cand, r_s4_dxneg;
    logic signed [PW-1:0] r_p1, r_p2;

    // compare stage: crossing when cross product and dx differ in sign
    logic signed [PW:0] w_diff;
    logic               w_hit;

    assign w_diff = (PW+1)'(r_p1) - (PW+1)'(r_p2);
    assign w_hit  = r_s4_cand && ((w_diff > 0 && r_s4_dxneg) || (w_diff < 0 && !r_s4_dxneg));

    t_tok r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld  <= 1'b0;
            r_s3.vld  <= 1'b0;
            r_s4.vld  <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_s2  <= i_stage;
            r_s3  <= r_s2;
            r_s4  <= r_s3;
            r_tok.vld <= r_s4.vld;
        end
        r_s2_ok    <= w_ok;
        r_s2_sec   <= i_ent_sec;
        r_s3_ok    <= r_s2_ok;
        r_s3_sec   <= r_s2_sec;
        r_x1       <= w_x1;
        r_y1       <= w_y1;
        r_x2       <= w_x2;
        r_y2       <= w_y2;
        r_s4_sec   <= r_s3_sec;
        r_s4_cand  <= w_cand;
        r_s4_dxneg <= w_dxneg;
        r_p1       <= w_p1;
        r_p2       <= w_p2;
        r_tok.scan <= r_s4.scan;
        r_tok.sec  <= r_s4.scan ? '0 : r_s4_sec;
        r_tok.hit  <= !r_s4.scan && w_hit;
    end

    assign o_tok = r_tok;

endmodule

FILE: rtl/psl_cell.sv
// ----------------------------------------------------------------------------
// psl_cell: one sector cell
// Holds the crossing parity of one sector; toggles it on a crossed wall of
// its sector, reports and clears it as the scan marker passes.
// ----------------------------------------------------------------------------
module psl_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psl_pkg::t_tok i_tok,
    output psl_pkg::t_tok o_tok
);
    import psl_pkg::*;

    logic r_par, n_par;
    t_tok r_tok, n_tok;

    always_comb begin
        n_par = r_par;
        n_tok = i_tok;
        if (i_tok.vld) begin
            if (i_tok.scan) begin
                // later cells overwrite, so the highest odd sector wins
                if (r_par) begin
                    n_tok.sec = SECTOR_W'(CELL_IDX);
                    n_tok.hit = 1'b1;
                end
                n_par = 1'b0;
            end else if (i_tok.hit && (i_tok.sec == SECTOR_W'(CELL_IDX))) begin
                n_par = ~r_par;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_par     <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_par     <= n_par;
            r_tok.vld <= n_tok.vld;
        end
        r_tok.scan <= n_tok.scan;
        r_tok.sec  <= n_tok.sec;
        r_tok.hit  <= n_tok.hit;
    end

    assign o_tok = r_tok;

endmodule

FILE: bench/psl_locator_checker.sv
// ----------------------------------------------------------------------------
// psl_locator_checker: result checker for the point-in-sector locator
// Watches both channels, keeps its own copy of the vertex table and wall
// list, predicts each query result and compares it field by field.
// ----------------------------------------------------------------------------
module psl_locator_checker (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_in_valid,
    input  logic                                     i_in_ready,
    input  logic [psl_pkg::OP_W-1:0]                 i_op,
    input  logic [psl_pkg::SLOT_W-1:0]               i_vertex_slot,
    input  logic signed [psl_pkg::COORD_FIELD_W-1:0] i_coord_x,
    input  logic signed [psl_pkg::COORD_FIELD_W-1:0] i_coord_y,
    input  logic [psl_pkg::SLOT_W-1:0]               i_first_vertex,
    input  logic [psl_pkg::SLOT_W-1:0]               i_second_vertex,
    input  logic [psl_pkg::SECTOR_W-1:0]             i_sector_id,
    input  logic                                     i_out_valid,
    input  logic                                     i_out_ready,
    input  logic [psl_pkg::SECTOR_W-1:0]             i_located_sector,
    input  logic                                     i_inside_found,
    input  logic                                     i_sector_changed,
    input  logic                                     i_list_full,
    output int                                       o_fail_count,
    output int                                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import psl_pkg::*;

    localparam int WALL_DEPTH = 256;

    typedef struct packed {
        logic [SECTOR_W-1:0] sector;
        logic                found;
        logic                changed;
        logic                full;
    } t_locate_word;

    logic signed [COORD_FIELD_W-1:0] corner_x [256];
    logic signed [COORD_FIELD_W-1:0] corner_y [256];
    logic [SLOT_W-1:0]               wall_a   [WALL_DEPTH];
    logic [SLOT_W-1:0]               wall_b   [WALL_DEPTH];
    logic [SECTOR_W-1:0]             wall_sec [WALL_DEPTH];
    int                              wall_count   = 0;
    logic [SECTOR_W-1:0]             home_sector  = '0;
    logic                            dropped_wall = 1'b0;
    t_locate_word                    located_q [$];
    t_locate_word                    want;

    // Ray towards -y: the wall counts when it spans the point's x, is not
    // vertical and passes below the point (cross product against dx).
    function automatic logic wall_crossed(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b,
                                          longint qx, longint qy);
        longint x1, y1, x2, y2, dx, wedge;
        x1 = longint'(corner_x[a]) - qx;
        y1 = longint'(corner_y[a]) - qy;
        x2 = longint'(corner_x[b]) - qx;
        y2 = longint'(corner_y[b]) - qy;
        if (!((x2 >= 0 && x1 <= 0) || (x2 <= 0 && x1 >= 0)))
            return 1'b0;
        dx    = x2 - x1;
        wedge = y1 * x2 - y2 * x1;
        return (dx > 0 && wedge < 0) || (dx < 0 && wedge > 0);
    endfunction

    function automatic t_locate_word locate_point(longint qx, longint qy);
        logic [63:0]         odd;
        logic [SECTOR_W-1:0] prev;
        t_locate_word        res;
        odd       = '0;
        prev      = home_sector;
        res.found = 1'b0;
        for (int e = 0; e < wall_count; e++) begin
            if (wall_crossed(wall_a[e], wall_b[e], qx, qy))
                odd[wall_sec[e]] ^= 1'b1;
        end
        for (int s = 0; s < 64; s++) begin
            if (odd[s]) begin
                home_sector = SECTOR_W'(s);
                res.found   = 1'b1;
            end
        end
        res.sector  = home_sector;
        res.changed = home_sector != prev;
        res.full    = dropped_wall;
        return res;
    endfunction

    task automatic compare_field(string name, logic [SECTOR_W-1:0] exp_v,
                                 logic [SECTOR_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (located_q.size() == 0) begin
                    $error("result word with none outstanding: sector %0d", i_located_sector);
                    o_fail_count++;
                end else begin
                    want = located_q.pop_front();
                    compare_field("located_sector", want.sector, i_located_sector);
                    compare_field("inside_found", SECTOR_W'(want.found),
                                  SECTOR_W'(i_inside_found));
                    compare_field("sector_changed", SECTOR_W'(want.changed),
                                  SECTOR_W'(i_sector_changed));
                    compare_field("list_full", SECTOR_W'(want.full), SECTOR_W'(i_list_full));
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_op)
                    OP_WRITE_VERTEX: begin
                        corner_x[i_vertex_slot] = i_coord_x;
                        corner_y[i_vertex_slot] = i_coord_y;
                    end
                    OP_APPEND: begin
                        if (wall_count >= WALL_DEPTH) begin
                            dropped_wall = 1'b1;
                        end else begin
                            wall_a[wall_count]   = i_first_vertex;
                            wall_b[wall_count]   = i_second_vertex;
                            wall_sec[wall_count] = i_sector_id;
                            wall_count++;
                        end
                    end
                    OP_CLEAR: begin
                        wall_count   = 0;
                        dropped_wall = 1'b0;
                    end
                    default: begin
                        located_q = {located_q, locate_point(longint'(i_coord_x),
                                                             longint'(i_coord_y))};
                    end
                endcase
            end
            o_pending = located_q.size();
        end
    end

endmodule

FILE: bench/tb_point_in_sector_locator_unit.sv
// ----------------------------------------------------------------------------
// tb_point_in_sector_locator_unit: testbench of the point-in-sector locator
// Drives vertex writes, wall appends, clears and queries with random gaps on
// both channels; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_point_in_sector_locator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import psl_pkg::*;

    // Stimulus stops once this many words have gone in.
    localparam int WORD_BUDGET = 1000;
    localparam int WALL_DEPTH  = 256;

    logic                            clk           = 1'b0;
    logic                            rst_n         = 1'b0;
    logic                            in_valid      = 1'b0;
    logic                            in_ready;
    logic [OP_W-1:0]                 op            = OP_WRITE_VERTEX;
    logic [SLOT_W-1:0]               vertex_slot   = '0;
    logic signed [COORD_FIELD_W-1:0] coord_x       = '0;
    logic signed [COORD_FIELD_W-1:0] coord_y       = '0;
    logic [SLOT_W-1:0]               first_vertex  = '0;
    logic [SLOT_W-1:0]               second_vertex = '0;
    logic [SECTOR_W-1:0]             sector_id     = '0;
    logic                            out_valid;
    logic                            out_ready     = 1'b0;
    logic [SECTOR_W-1:0]             located_sector;
    logic                            inside_found;
    logic                            sector_changed;
    logic                            list_full;
    int                              fail_count;
    int                              pending;

    // Stimulus bookkeeping: which vertex slots hold a value, how long the
    // wall list is, and whether idling is switched off for a stretch.
    bit written [256];
    int walls_held = 0;
    int words_sent = 0;
    bit calm       = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    point_in_sector_locator_unit dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_op             (op),
        .i_vertex_slot    (vertex_slot),
        .i_coord_x        (coord_x),
        .i_coord_y        (coord_y),
        .i_first_vertex   (first_vertex),
        .i_second_vertex  (second_vertex),
        .i_sector_id      (sector_id),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_located_sector (located_sector),
        .o_inside_found   (inside_found),
        .o_sector_changed (sector_changed),
        .o_list_full      (list_full)
    );

    psl_locator_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_op             (op),
        .i_vertex_slot    (vertex_slot),
        .i_coord_x        (coord_x),
        .i_coord_y        (coord_y),
        .i_first_vertex   (first_vertex),
        .i_second_vertex  (second_vertex),
        .i_sector_id      (sector_id),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_located_sector (located_sector),
        .i_inside_found   (inside_found),
        .i_sector_changed (sector_changed),
        .i_list_full      (list_full),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Stall the result channel now and then, except during the calm stretch.
    always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 8);

    // Present one word and hold it until taken. Valid is only lowered while
    // idling, so back-to-back words keep it high without a glitch.
    task automatic send_word(logic [OP_W-1:0] w_op, logic [SLOT_W-1:0] w_slot,
                             logic signed [COORD_FIELD_W-1:0] w_x,
                             logic signed [COORD_FIELD_W-1:0] w_y,
                             logic [SLOT_W-1:0] w_a, logic [SLOT_W-1:0] w_b,
                             logic [SECTOR_W-1:0] w_sec);
        while (!calm && $urandom_range(99) < 8) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= w_op;
        vertex_slot   <= w_slot;
        coord_x       <= w_x;
        coord_y       <= w_y;
        first_vertex  <= w_a;
        second_vertex <= w_b;
        sector_id     <= w_sec;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    task automatic put_vertex(logic [SLOT_W-1:0] slot, logic signed [COORD_FIELD_W-1:0] x,
                              logic signed [COORD_FIELD_W-1:0] y);
        send_word(OP_WRITE_VERTEX, slot, x, y, SLOT_W'($urandom), SLOT_W'($urandom),
                  SECTOR_W'($urandom));
        written[slot] = 1'b1;
    endtask

    // Never let a wall name a vertex that holds no value: write it first.
    task automatic add_wall(logic [SLOT_W-1:0] a, logic [SLOT_W-1:0] b,
                            logic [SECTOR_W-1:0] sec);
        if (!written[a])
            put_vertex(a, COORD_FIELD_W'($urandom), COORD_FIELD_W'($urandom));
        if (!written[b])
            put_vertex(b, COORD_FIELD_W'($urandom), COORD_FIELD_W'($urandom));
        send_word(OP_APPEND, SLOT_W'($urandom), COORD_FIELD_W'($urandom),
                  COORD_FIELD_W'($urandom), a, b, sec);
        if (walls_held < WALL_DEPTH)
            walls_held++;
    endtask

    task automatic drop_walls();
        send_word(OP_CLEAR, SLOT_W'($urandom), COORD_FIELD_W'($urandom),
                  COORD_FIELD_W'($urandom), SLOT_W'($urandom), SLOT_W'($urandom),
                  SECTOR_W'($urandom));
        walls_held = 0;
    endtask

    task automatic ask_point(logic signed [COORD_FIELD_W-1:0] x,
                             logic signed [COORD_FIELD_W-1:0] y);
        send_word(OP_QUERY, SLOT_W'($urandom), x, y, SLOT_W'($urandom), SLOT_W'($urandom),
                  SECTOR_W'($urandom));
    endtask

    function automatic logic signed [COORD_FIELD_W-1:0] clamp_coord(int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return COORD_FIELD_W'(v);
    endfunction

    function automatic int spread(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    // Well-formed work: closed rings of walls in one to three sectors, then
    // a handful of queries: most around the last ring, some right on a corner, some anywhere.
    task automatic build_sectors();
        int                              cx, cy, r, k;
        logic [SLOT_W-1:0]               ring [6];
        logic signed [COORD_FIELD_W-1:0] rx [6];
        logic signed [COORD_FIELD_W-1:0] ry [6];
        logic [SECTOR_W-1:0]             sec;
        int                              pick;
        if ($urandom_range(99) < 70)
            drop_walls();
        repeat ($urandom_range(1, 3)) begin
            k   = $urandom_range(3, 6);
            r   = ($urandom_range(99) < 80) ? $urandom_range(1, 2000) : 32767;
            cx  = spread(30000);
            cy  = spread(30000);
            sec = SECTOR_W'($urandom);
            for (int i = 0; i < k; i++) begin
                ring[i] = SLOT_W'($urandom);
                rx[i]   = clamp_coord(cx + spread(r));
                ry[i]   = clamp_coord(cy + spread(r));
                put_vertex(ring[i], rx[i], ry[i]);
            end
            for (int i = 0; i < k; i++)
                add_wall(ring[i], ring[(i + 1) % k], sec);
        end
        repeat ($urandom_range(2, 5)) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                pick = $urandom_range(k - 1);
                ask_point(rx[pick], ry[pick]);
            end else if (pick < 35) begin
                ask_point(COORD_FIELD_W'($urandom), COORD_FIELD_W'($urandom));
            end else begin
                ask_point(clamp_coord(cx + spread(r)), clamp_coord(cy + spread(r)));
            end
        end
    endtask

    // Single words of any kind with random content (a wall may bring vertex writes first).
    task automatic stray_word();
        case ($urandom_range(3))
            0: put_vertex(SLOT_W'($urandom), COORD_FIELD_W'($urandom),
                          COORD_FIELD_W'($urandom));
            1: add_wall(SLOT_W'($urandom), SLOT_W'($urandom), SECTOR_W'($urandom));
            2: drop_walls();
            default: ask_point(COORD_FIELD_W'($urandom), COORD_FIELD_W'($urandom));
        endcase
    endtask

    // Fill the wall list, push past the end so appends get dropped, query a
    // full list, then clear and query again to see the full flag go away.
    task automatic overflow_list();
        drop_walls();
        while (walls_held < WALL_DEPTH)
            add_wall(SLOT_W'($urandom), SLOT_W'($urandom), SECTOR_W'($urandom));
        ask_point(COORD_FIELD_W'($urandom), COORD_FIELD_W'($urandom));
        repeat (3)
            add_wall(SLOT_W'($urandom), SLOT_W'($urandom), SECTOR_W'($urandom));
        ask_point(COORD_FIELD_W'($urandom), COORD_FIELD_W'($urandom));
        ask_point(16'sh0000, 16'sh0000);
        drop_walls();
        ask_point(COORD_FIELD_W'($urandom), COORD_FIELD_W'($urandom));
    endtask

    initial begin
        bit overflowed;
        overflowed = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Query an empty list straight out of reset: nothing found, sector 0.
        ask_point(16'sh0000, 16'sh0000);
        // Square over the whole coordinate range, owned by the top sector.
        put_vertex(8'd0, 16'sh8000, 16'sh8000);
        put_vertex(8'd1, 16'sh7fff, 16'sh8000);
        put_vertex(8'd2, 16'sh7fff, 16'sh7fff);
        put_vertex(8'd3, 16'sh8000, 16'sh7fff);
        add_wall(8'd0, 8'd1, 6'd63);
        add_wall(8'd1, 8'd2, 6'd63);
        add_wall(8'd2, 8'd3, 6'd63);
        add_wall(8'd3, 8'd0, 6'd63);
        ask_point(16'sh0000, 16'sh0000);
        ask_point(16'sh7fff, 16'sh7fff);
        ask_point(16'sh8000, 16'sh8000);
        // Small triangle in sector 0 inside it: the higher sector must win.
        put_vertex(8'd4, -16'sd50, -16'sd50);
        put_vertex(8'd5, 16'sd50, -16'sd50);
        put_vertex(8'd255, 16'sd0, 16'sd50);
        add_wall(8'd4, 8'd5, 6'd0);
        add_wall(8'd5, 8'd255, 6'd0);
        add_wall(8'd255, 8'd4, 6'd0);
        ask_point(16'sh0000, 16'sh0000);
        // Cleared list: nothing odd, so the current sector is held.
        drop_walls();
        ask_point(16'sh0000, 16'sh0000);
        add_wall(8'd4, 8'd5, 6'd0);
        add_wall(8'd5, 8'd255, 6'd0);
        add_wall(8'd255, 8'd4, 6'd0);
        ask_point(16'sh0000, 16'sh0000);
        // On the horizontal bottom edge and on a corner.
        ask_point(16'sh0000, -16'sd50);
        ask_point(16'sd50, -16'sd50);

        while (words_sent < WORD_BUDGET) begin
            calm = words_sent >= 400 && words_sent < 600;
            if (!overflowed && words_sent >= 650) begin
                overflow_list();
                overflowed = 1'b1;
            end else if ($urandom_range(99) < 60) begin
                build_sectors();
            end else begin
                stray_word();
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain: wait for every outstanding query, then go on watching for anything stray.
        do @(negedge clk); while (pending != 0);
        repeat (400) @(negedge clk);
        if (fail_count == 0)
            $display("** point_in_sector_locator_unit: PASSED **");
        else
            $display("** point_in_sector_locator_unit: FAILED **");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("** point_in_sector_locator_unit: FAILED **");
        $finish;
    end

endmodule

FILE: point_in_sector_locator_unit.f
rtl/psl_pkg.sv
rtl/psl_ram.sv
rtl/psl_cross.sv
rtl/psl_cell.sv
rtl/point_in_sector_locator_unit.sv
bench/psl_locator_checker.sv
bench/tb_point_in_sector_locator_unit.sv
